FILE: src/smsd_pkg.sv
// Shared types and constants for the sliding median spike detector.
// No dependencies; used by the cell, the cell row and the top level.
package smsd_pkg;

	// Width of the window size input and of the alert counter.
	localparam int WINDOW_BITS = 7;
	localparam int COUNT_BITS  = 32;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	// Flags one cell hands to its neighbors in every cycle.
	typedef struct packed {
		logic gt;     // cell is empty or holds a value above the new sample
		logic del;    // cell holds the oldest sample, which leaves this beat
		logic above;  // the leaving sample sits in a cell below this one
	} cell_flags_t;

	// Control shared by every cell of the row.
	typedef struct packed {
		logic advance;  // an input beat is taken this cycle
		logic full;     // the window was full before this beat
	} cell_ctrl_t;

endpackage

FILE: src/smsd_cell.sv
// One cell of the sorted row: a sample and its age in the window.
// Depends on smsd_pkg for the neighbor flag and control structs.
module smsd_cell #(
	parameter int IDX         = 0,
	parameter int SAMPLE_BITS = 16,
	parameter int AGE_W       = 6,
	parameter int CNT_W       = 7
) (
	input  logic                     clk,
	input  smsd_pkg::cell_ctrl_t     ctrl,
	input  logic [SAMPLE_BITS-1:0]   sample,
	input  logic [CNT_W-1:0]         fill,
	input  logic [CNT_W-1:0]         win,
	input  logic [CNT_W-1:0]         lo_idx,
	input  logic [CNT_W-1:0]         hi_idx,
	input  smsd_pkg::cell_flags_t    left_flags,
	input  logic [SAMPLE_BITS-1:0]   left_value,
	input  logic [AGE_W-1:0]         left_age,
	input  smsd_pkg::cell_flags_t    right_flags,
	input  logic [SAMPLE_BITS-1:0]   right_value,
	input  logic [AGE_W-1:0]         right_age,
	output smsd_pkg::cell_flags_t    flags,
	output logic [SAMPLE_BITS-1:0]   value,
	output logic [AGE_W-1:0]         age,
	output logic [SAMPLE_BITS-1:0]   lo_tap,
	output logic [SAMPLE_BITS-1:0]   hi_tap
);
	import smsd_pkg::*;

	localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

	logic [SAMPLE_BITS-1:0] value_q;
	logic [AGE_W-1:0]       age_q;
	logic                   occupied;
	logic [SAMPLE_BITS-1:0] value_d;
	logic [AGE_W-1:0]       age_d;

	// Local view: occupancy from the fill count, order against the new sample.
	always_comb begin
		occupied    = (MY_IDX < fill);
		flags.gt    = !occupied || (value_q > sample);
		flags.del   = ctrl.full && occupied && (CNT_W'(age_q) == (win - CNT_W'(1)));
		flags.above = left_flags.above | left_flags.del;
	end

	// Pick the sample that lands here: stay, slide down over the leaving
	// one, slide up to make room for the new one, or take the new sample.
	always_comb begin
		if ((flags.above == flags.gt) && !flags.del) begin
			value_d = value_q;
			age_d   = age_q + AGE_W'(1);
		end else if (right_flags.above && !right_flags.gt) begin
			value_d = right_value;
			age_d   = right_age + AGE_W'(1);
		end else if (left_flags.gt && !left_flags.above && !left_flags.del) begin
			value_d = left_value;
			age_d   = left_age + AGE_W'(1);
		end else begin
			value_d = sample;
			age_d   = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.advance) begin
			value_q <= value_d;
			age_q   <= age_d;
		end
	end

	// Median taps for the two middle positions of the window.
	assign lo_tap = (MY_IDX == lo_idx) ? value_q : '0;
	assign hi_tap = (MY_IDX == hi_idx) ? value_q : '0;
	assign value  = value_q;
	assign age    = age_q;

endmodule

FILE: src/smsd_chain.sv
// Row of sorted cells with neighbor links and the median tap reduction.
// Depends on smsd_pkg and smsd_cell.
module smsd_chain #(
	parameter int MAX_WINDOW  = 64,
	parameter int SAMPLE_BITS = 16,
	parameter int AGE_W       = 6,
	parameter int CNT_W       = 7
) (
	input  logic                   clk,
	input  smsd_pkg::cell_ctrl_t   ctrl,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic [CNT_W-1:0]       fill,
	input  logic [CNT_W-1:0]       win,
	input  logic [CNT_W-1:0]       lo_idx,
	input  logic [CNT_W-1:0]       hi_idx,
	output logic [SAMPLE_BITS:0]   median_x2
);
	import smsd_pkg::*;

	cell_flags_t            flags_w  [MAX_WINDOW];
	logic [SAMPLE_BITS-1:0] value_w  [MAX_WINDOW];
	logic [AGE_W-1:0]       age_w    [MAX_WINDOW];
	logic [SAMPLE_BITS-1:0] lo_tap_w [MAX_WINDOW];
	logic [SAMPLE_BITS-1:0] hi_tap_w [MAX_WINDOW];
	logic [SAMPLE_BITS-1:0] lo_val;
	logic [SAMPLE_BITS-1:0] hi_val;

	// The row itself; the ends see all-zero neighbor flags and values.
	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		cell_flags_t            l_flags;
		logic [SAMPLE_BITS-1:0] l_value;
		logic [AGE_W-1:0]       l_age;
		cell_flags_t            r_flags;
		logic [SAMPLE_BITS-1:0] r_value;
		logic [AGE_W-1:0]       r_age;

		if (i == 0) begin : g_left_end
			assign l_flags = '0;
			assign l_value = '0;
			assign l_age   = '0;
		end else begin : g_left
			assign l_flags = flags_w[i-1];
			assign l_value = value_w[i-1];
			assign l_age   = age_w[i-1];
		end

		if (i == MAX_WINDOW - 1) begin : g_right_end
			assign r_flags = '0;
			assign r_value = '0;
			assign r_age   = '0;
		end else begin : g_right
			assign r_flags = flags_w[i+1];
			assign r_value = value_w[i+1];
			assign r_age   = age_w[i+1];
		end

		smsd_cell #(
			.IDX(i), .SAMPLE_BITS(SAMPLE_BITS), .AGE_W(AGE_W), .CNT_W(CNT_W)
		) u_cell (
			.clk(clk), .ctrl(ctrl), .sample(sample), .fill(fill), .win(win),
			.lo_idx(lo_idx), .hi_idx(hi_idx),
			.left_flags(l_flags), .left_value(l_value), .left_age(l_age),
			.right_flags(r_flags), .right_value(r_value), .right_age(r_age),
			.flags(flags_w[i]), .value(value_w[i]), .age(age_w[i]),
			.lo_tap(lo_tap_w[i]), .hi_tap(hi_tap_w[i])
		);
	end

	// Exactly one cell drives each tap; the rest give zero.
	always_comb begin
		lo_val = '0;
		hi_val = '0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			lo_val = lo_val | lo_tap_w[i];
			hi_val = hi_val | hi_tap_w[i];
		end
	end

	assign median_x2 = {1'b0, lo_val} + {1'b0, hi_val};

endmodule

FILE: src/sliding_median_spike_detector.sv
// A result is registered when its input beat is taken and is valid from the next cycle.
// Throughput: one beat per cycle unless the output stalls; the sorted row
// drops a full window's oldest sample and inserts the new one in the same cycle as the beat.
// Reset clears the fill count, the alert count and the output valid flag and
// sets the window size to one; cell contents and the result payload are not cleared.
module sliding_median_spike_detector #(
	parameter int MAX_WINDOW  = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [smsd_pkg::WINDOW_BITS-1:0]   window_size,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [SAMPLE_BITS-1:0]             sample_value,
	input  logic                               start_sequence,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               spike_flag,
	output logic                               window_full,
	output logic [smsd_pkg::COUNT_BITS-1:0]    alert_count,
	output logic [SAMPLE_BITS:0]               current_median_x2
);
	import smsd_pkg::*;

	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int AGE_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

	logic [CNT_W-1:0]      win_q;
	logic [CNT_W-1:0]      fill_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  out_valid_q;
	logic                  spike_q;
	logic                  full_q;
	logic [COUNT_BITS-1:0] alert_q;
	logic [SAMPLE_BITS:0]  median_q;

	logic                  cfg_take;
	logic                  in_take;
	logic [CNT_W-1:0]      win_d;
	logic [CNT_W-1:0]      fill_eff;
	logic [COUNT_BITS-1:0] count_eff;
	logic [COUNT_BITS-1:0] count_d;
	logic [CNT_W-1:0]      lo_idx;
	logic [CNT_W-1:0]      hi_idx;
	logic [SAMPLE_BITS:0]  median_x2;
	logic                  spike;
	cell_ctrl_t            ctrl;

	assign cfg_ready = 1'b1;
	assign cfg_take  = cfg_valid & cfg_ready;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_take   = in_valid & in_ready;

	// Window size clamped into one to the row length.
	always_comb begin
		if (window_size == '0) begin
			win_d = CNT_W'(1);
		end else if (32'(window_size) > MAX_WINDOW) begin
			win_d = CNT_W'(MAX_WINDOW);
		end else begin
			win_d = CNT_W'(window_size);
		end
	end

	// A new sequence empties the window and the count before this beat.
	always_comb begin
		fill_eff     = start_sequence ? '0 : fill_q;
		count_eff    = start_sequence ? '0 : count_q;
		ctrl.advance = in_take;
		ctrl.full    = (fill_eff >= win_q);
		lo_idx       = (win_q - CNT_W'(1)) >> 1;
		hi_idx       = win_q >> 1;
	end

	smsd_chain #(
		.MAX_WINDOW(MAX_WINDOW), .SAMPLE_BITS(SAMPLE_BITS), .AGE_W(AGE_W), .CNT_W(CNT_W)
	) u_chain (
		.clk(clk), .ctrl(ctrl), .sample(sample_value), .fill(fill_eff), .win(win_q),
		.lo_idx(lo_idx), .hi_idx(hi_idx), .median_x2(median_x2)
	);

	// Spike test against twice the median and the saturating alert count.
	always_comb begin
		spike   = ctrl.full && ({1'b0, sample_value} >= median_x2);
		count_d = (spike && (count_eff != COUNT_MAX)) ? count_eff + COUNT_BITS'(1)
		                                               : count_eff;
	end

	// Window size, fill level and alert count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= CNT_W'(1);
			fill_q  <= '0;
			count_q <= '0;
		end else if (cfg_take) begin
			win_q  <= win_d;
			fill_q <= '0;
		end else if (in_take) begin
			fill_q  <= ctrl.full ? fill_eff : fill_eff + CNT_W'(1);
			count_q <= count_d;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (in_take) begin
			spike_q  <= spike;
			full_q   <= ctrl.full;
			alert_q  <= count_d;
			median_q <= ctrl.full ? median_x2 : '0;
		end
	end

	assign out_valid         = out_valid_q;
	assign spike_flag        = spike_q;
	assign window_full       = full_q;
	assign alert_count       = alert_q;
	assign current_median_x2 = median_q;

endmodule

FILE: src/smsd_checker.sv
// Port-level checks for the sliding median spike detector and their binding.
// Depends on smsd_pkg and on the top level's ports.
module smsd_checker #(
	parameter int SAMPLE_BITS = 16
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic                            spike_flag,
	input logic                            window_full,
	input logic [smsd_pkg::COUNT_BITS-1:0] alert_count,
	input logic [SAMPLE_BITS:0]            current_median_x2
);
	import smsd_pkg::*;

	// A stalled result beat keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(spike_flag)
			&& $stable(alert_count) && $stable(current_median_x2))
		else $error("result beat changed while stalled");

	// A spike needs a full window.
	a_spike_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && spike_flag |-> window_full)
		else $error("spike flagged without a full window");

	// No median is reported while the window is filling.
	a_median_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !window_full |-> current_median_x2 == '0)
		else $error("median reported for a partial window");

	// A flagged beat has been counted.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && spike_flag |-> alert_count != '0)
		else $error("spike not counted");

endmodule

bind sliding_median_spike_detector smsd_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_smsd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.spike_flag(spike_flag),
	.window_full(window_full),
	.alert_count(alert_count),
	.current_median_x2(current_median_x2)
);
